[src/qpht_pkg.sv]
// ----------------------------------------------------------------------------
// qpht_pkg: shared types and constants
// widths, codes and controller/datapath command and status structs
// ----------------------------------------------------------------------------
package qpht_pkg;

  localparam int TableSize  = 64;
  localparam int KeyBits    = 32;
  localparam int ValueBits  = 32;
  localparam int ProbeLimit = 64;

  localparam int SlotBits  = $clog2(TableSize);
  localparam int CountBits = $clog2(TableSize + 1);
  localparam int ProbeBits = $clog2(ProbeLimit + 1);

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_GET    = 2'd0;
  localparam kind_t KIND_PUT    = 2'd1;
  localparam kind_t KIND_REMOVE = 2'd2;
  localparam kind_t KIND_CLEAR  = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOTFOUND = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_NULL     = 2'd3;

  typedef logic [1:0] tag_t;
  localparam tag_t TAG_EMPTY = 2'd0;
  localparam tag_t TAG_LIVE  = 2'd1;
  localparam tag_t TAG_TOMB  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request, start probe 0
    logic issue;       // read slot at current probe
    logic advance;     // step to next probe
    logic clear_step;  // clear one tag
    logic write_new;   // write key/value/tag live at chosen slot
    logic write_val;   // overwrite value at hit slot
    logic write_tomb;  // tag hit slot as tombstone
    logic finish;      // latch result
    status_t status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    kind_t kind;
    logic  null_op;
    logic  is_empty;   // slot read back empty
    logic  is_hit;     // slot live and key matches
    logic  is_tomb;
    logic  last_probe;
    logic  have_tomb;
    logic  table_half;
    logic  live_zero;
    logic  clear_last;
  } stat_t;

endpackage

[src/qpht_if.sv]
// ----------------------------------------------------------------------------
// qpht_if: valid/ready channel
// carries one payload beat of type payload_t
// ----------------------------------------------------------------------------
interface qpht_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/qpht_ram.sv]
// ----------------------------------------------------------------------------
// qpht_ram: generic ram with one write port and one read port
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
module qpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/qpht_datapath.sv]
// ----------------------------------------------------------------------------
// qpht_datapath: slot memories, probe walker and result registers
// tags live in a ram cleared by a sweep; keys and values in two more rams
// ----------------------------------------------------------------------------
module qpht_datapath
  import qpht_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output stat_t                stat,
  input  kind_t                in_kind,
  input  logic [KeyBits-1:0]   in_key,
  input  logic [ValueBits-1:0] in_value,
  output status_t              res_status,
  output logic [ValueBits-1:0] res_value,
  output logic [CountBits-1:0] res_count
);
  kind_t                kind;
  logic [KeyBits-1:0]   key;
  logic [ValueBits-1:0] value;
  logic [SlotBits-1:0]  slot;      // current probe slot
  logic [SlotBits-1:0]  step;      // increment from probe i to probe i+1
  logic [ProbeBits-1:0] probe;
  logic [SlotBits-1:0]  tomb_slot;
  logic                 have_tomb;
  logic [SlotBits-1:0]  clr_addr;
  logic [CountBits-1:0] live_count;
  logic [CountBits-1:0] used_slots;

  tag_t                 tag_rd;
  logic [KeyBits-1:0]   key_rd;
  logic [ValueBits-1:0] val_rd;
  logic                 is_hit;

  // offset(i) = i/2 + i*i/2; offset(i+1)-offset(i) = i for even i, i+2 for odd i
  logic [ProbeBits-1:0] delta;
  assign delta = probe + ProbeBits'({probe[0], 1'b0});
  assign step  = SlotBits'(delta);

  logic                tag_we;
  logic [SlotBits-1:0] tag_wa;
  tag_t                tag_wd;
  logic                kv_we;
  logic                v_we;
  logic [SlotBits-1:0] kv_wa;

  always_comb begin
    tag_we = cmd.clear_step | cmd.write_new | cmd.write_tomb;
    tag_wa = cmd.clear_step ? clr_addr : (cmd.write_new && have_tomb) ? tomb_slot : slot;
    tag_wd = cmd.clear_step ? TAG_EMPTY : cmd.write_tomb ? TAG_TOMB : TAG_LIVE;
    kv_we  = cmd.write_new;
    v_we   = cmd.write_new | cmd.write_val;
    kv_wa  = (cmd.write_new && have_tomb) ? tomb_slot : slot;
  end

  qpht_ram #(.Width(2), .Depth(TableSize)) u_tag (
    .clk, .we(tag_we), .waddr(tag_wa), .wdata(tag_wd), .raddr(slot), .rdata(tag_rd));
  qpht_ram #(.Width(KeyBits), .Depth(TableSize)) u_key (
    .clk, .we(kv_we), .waddr(kv_wa), .wdata(key), .raddr(slot), .rdata(key_rd));
  qpht_ram #(.Width(ValueBits), .Depth(TableSize)) u_val (
    .clk, .we(v_we), .waddr(kv_wa), .wdata(value), .raddr(slot), .rdata(val_rd));

  assign is_hit = tag_rd == TAG_LIVE && key_rd == key;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      used_slots <= '0;
      clr_addr   <= '0;
      have_tomb  <= 1'b0;
    end else begin
      if (cmd.load) begin
        kind      <= in_kind;
        key       <= in_key;
        value     <= in_value;
        slot      <= in_key[SlotBits-1:0];
        probe     <= '0;
        have_tomb <= 1'b0;
        clr_addr  <= '0;
      end
      if (cmd.advance) begin
        slot  <= slot + step;
        probe <= probe + 1'b1;
        if (tag_rd == TAG_TOMB && !have_tomb) begin
          have_tomb <= 1'b1;
          tomb_slot <= slot;
        end
      end
      if (cmd.clear_step) begin
        clr_addr   <= clr_addr + 1'b1;
        live_count <= '0;
        used_slots <= '0;
      end
      if (cmd.write_new) begin
        live_count <= live_count + 1'b1;
        // a tombstone met at the last probe is reused like an earlier one
        if (!have_tomb && tag_rd == TAG_EMPTY) begin
          used_slots <= used_slots + 1'b1;
        end
      end
      if (cmd.write_tomb && live_count != '0) begin
        live_count <= live_count - 1'b1;
      end
      if (cmd.finish) begin
        res_status <= cmd.status;
        res_value  <= (cmd.status == ST_OK && kind != KIND_CLEAR && is_hit) ? val_rd : '0;
      end
    end
  end

  assign res_count = live_count;

  always_comb begin
    stat.kind       = kind;
    stat.null_op    = key == '0 || (kind == KIND_PUT && value == '0);
    stat.is_empty   = tag_rd == TAG_EMPTY;
    stat.is_hit     = is_hit;
    stat.is_tomb    = tag_rd == TAG_TOMB;
    stat.last_probe = probe == ProbeBits'(ProbeLimit - 1);
    stat.have_tomb  = have_tomb;
    stat.table_half = {used_slots, 1'b0} >= (CountBits + 1)'(TableSize);
    stat.live_zero  = live_count == '0;
    stat.clear_last = clr_addr == SlotBits'(TableSize - 1);
  end

endmodule

[src/qpht_ctrl.sv]
// ----------------------------------------------------------------------------
// qpht_ctrl: request sequencer
// walks probes one slot read at a time and issues memory writes
// ----------------------------------------------------------------------------
module qpht_ctrl
  import qpht_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_READ, S_CHECK, S_CLEAR, S_WRITE, S_DONE
  } state_t;

  state_t  state;
  status_t res;
  logic    write_new;
  logic    write_val;
  logic    write_tomb;
  logic    init_sweep;  // tag sweep after reset, gives no response

  assign in_ready = state == S_IDLE && !out_valid;

  always_comb begin
    cmd            = '0;
    cmd.load       = in_valid && in_ready;
    cmd.issue      = state == S_READ;
    cmd.clear_step = state == S_CLEAR;
    cmd.write_new  = state == S_WRITE && write_new;
    cmd.write_val  = state == S_WRITE && write_val;
    cmd.write_tomb = state == S_WRITE && write_tomb;
    cmd.advance    = state == S_CHECK && !stat.is_empty && !stat.is_hit && !stat.last_probe;
    cmd.finish     = state == S_DONE;
    cmd.status     = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      init_sweep <= 1'b1;
      out_valid  <= 1'b0;
      res        <= ST_OK;
      write_new  <= 1'b0;
      write_val  <= 1'b0;
      write_tomb <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          write_new  <= 1'b0;
          write_val  <= 1'b0;
          write_tomb <= 1'b0;
          res        <= ST_OK;
          if (stat.kind == KIND_CLEAR) begin
            state <= S_CLEAR;
          end else if (stat.null_op) begin
            res   <= ST_NULL;
            state <= S_DONE;
          end else if (stat.kind == KIND_GET && stat.live_zero) begin
            res   <= ST_NOTFOUND;
            state <= S_DONE;
          end else if (stat.kind == KIND_PUT && stat.table_half) begin
            res   <= ST_FULL;
            state <= S_DONE;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (stat.is_hit) begin
            // keep slot so result value is read back unchanged
            write_val  <= stat.kind == KIND_PUT;
            write_tomb <= stat.kind == KIND_REMOVE;
            state      <= S_WRITE;
          end else if (stat.is_empty || stat.last_probe) begin
            if (stat.kind == KIND_PUT &&
                (stat.is_empty || stat.have_tomb || stat.is_tomb)) begin
              write_new <= 1'b1;
              state     <= S_WRITE;
            end else begin
              res   <= stat.is_empty ? ST_NOTFOUND : ST_FULL;
              state <= S_DONE;
            end
          end else begin
            state <= S_READ;
          end
        end
        S_CLEAR: begin
          if (stat.clear_last) begin
            if (init_sweep) begin
              init_sweep <= 1'b0;
              state      <= S_IDLE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WRITE: state <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !out_valid) else $error("load while result pending");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_valid) else $error("result not shown");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.write_new, cmd.write_val, cmd.write_tomb}) <= 1)
    else $error("conflicting writes");
endmodule

[src/quadratic_probe_hash_table.sv]
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table: open-addressed key/value table
// get, put, remove and clear with quadratic probing and tombstones
// ----------------------------------------------------------------------------
// usage
//   req carries kind, key and value; rsp carries status, value_out and
//   entry_count; both are valid/ready channels, a beat moves when both high
//   one request is in flight at a time; a new request is taken once the
//   previous response beat has been taken
// sequence
//   requests answered without probing (null operand, empty get, full put)
//   go from decode straight to done; probing requests pass a read and a
//   check state per probe visited, plus a write state when a probe hits
//   or a new entry is written; the tag, key and value memories have a
//   registered read, so each probe has an address step and a compare step
//   clear sweeps the tag memory one slot per cycle, then goes to done
// reset
//   rst clears the counts and the sequencer, then the sequencer sweeps the
//   tag memory to empty one slot per cycle; req ready stays low until the
//   sweep ends
// stall
//   a held response keeps req ready low; nothing is lost or repeated
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table
  import qpht_pkg::*;
(
  input logic clk,
  input logic rst,
  qpht_if.sink   req,
  qpht_if.source rsp
);
  cmd_t  cmd;
  stat_t stat;

  // request payload: kind, key, value packed msb first
  kind_t                in_kind;
  logic [KeyBits-1:0]   in_key;
  logic [ValueBits-1:0] in_value;
  assign {in_kind, in_key, in_value} = req.data;

  status_t              res_status;
  logic [ValueBits-1:0] res_value;
  logic [CountBits-1:0] res_count;
  assign rsp.data = {res_status, res_value, res_count};

  // sequencer: accepts a request and steps the datapath
  qpht_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .cmd, .stat
  );

  // slot memories, probe walker, counts and result registers
  qpht_datapath u_dp (
    .clk, .rst, .cmd, .stat,
    .in_kind, .in_key, .in_value,
    .res_status, .res_value, .res_count
  );
endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quadratic_probe_hash_table
// a queue-fed driver offers get/put/remove/clear beats with random gaps, a
// shadow table predicts every response, and the monitor compares each
// response beat field by field under random backpressure
// ----------------------------------------------------------------------------
module testbench;
  import qpht_pkg::*;

  // request and response beats as the block sees them
  typedef struct packed {
    kind_t                kind;
    logic [KeyBits-1:0]   key;
    logic [ValueBits-1:0] value;
  } req_t;

  typedef struct packed {
    status_t              status;
    logic [ValueBits-1:0] value_out;
    logic [CountBits-1:0] entry_count;
  } rsp_t;

  localparam int RandomItems = 1950;
  localparam int PoolSize    = 48;
  localparam int HoldCycles  = 400;   // long receiver hold-off
  localparam int HoldAtBeat  = 900;
  localparam int PauseAtItem = 1400;  // sender waits for the table to drain here

  logic clk;
  logic rst;

  qpht_if #(.payload_t(req_t)) req_ch ();
  qpht_if #(.payload_t(rsp_t)) rsp_ch ();

  quadratic_probe_hash_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // shadow copy of the table
  tag_t                 shadow_tag [TableSize];
  logic [KeyBits-1:0]   shadow_key [TableSize];
  logic [ValueBits-1:0] shadow_val [TableSize];
  int unsigned          shadow_live;
  int unsigned          shadow_used;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [KeyBits-1:0] key_pool [PoolSize];

  int errors;
  int sent_count;
  int beat_count;
  int status_seen [4];

  // slot visited by probe number i for a given key
  function automatic int unsigned probe_slot(logic [KeyBits-1:0] k, int unsigned i);
    int unsigned off;
    off = i / 2 + (i * i) / 2;
    return (k % TableSize + off) % TableSize;
  endfunction

  // look for a live slot holding k: 0 hit, 1 empty reached, 2 probe limit
  function automatic int find_slot(logic [KeyBits-1:0] k, output int unsigned where);
    int unsigned s;
    where = 0;
    for (int unsigned i = 0; i < ProbeLimit; i++) begin
      s = probe_slot(k, i);
      if (shadow_tag[s] == TAG_EMPTY) return 1;
      if (shadow_tag[s] == TAG_LIVE && shadow_key[s] == k) begin
        where = s;
        return 0;
      end
    end
    return 2;
  endfunction

  // apply one accepted request to the shadow table, return the response
  function automatic rsp_t table_apply(req_t r);
    rsp_t        e;
    int          res;
    int unsigned where;
    int unsigned s;
    int unsigned tomb;
    int unsigned empty;
    bit          have_tomb;
    bit          have_empty;
    bit          done;
    e.status    = ST_OK;
    e.value_out = '0;
    have_tomb   = 0;
    have_empty  = 0;
    done        = 0;
    tomb        = 0;
    empty       = 0;
    if (r.kind == KIND_CLEAR) begin
      for (int i = 0; i < TableSize; i++) shadow_tag[i] = TAG_EMPTY;
      shadow_live = 0;
      shadow_used = 0;
    end else if (r.key == 0 || (r.kind == KIND_PUT && r.value == 0)) begin
      e.status = ST_NULL;
    end else if (r.kind == KIND_GET) begin
      if (shadow_live == 0) begin
        e.status = ST_NOTFOUND;
      end else begin
        res = find_slot(r.key, where);
        if (res == 0) e.value_out = shadow_val[where];
        else e.status = (res == 1) ? ST_NOTFOUND : ST_FULL;
      end
    end else if (r.kind == KIND_REMOVE) begin
      res = find_slot(r.key, where);
      if (res == 0) begin
        e.value_out = shadow_val[where];
        shadow_tag[where] = TAG_TOMB;
        if (shadow_live > 0) shadow_live--;
      end else begin
        e.status = (res == 1) ? ST_NOTFOUND : ST_FULL;
      end
    end else if (shadow_used * 2 >= TableSize) begin
      // refused once half the slots are used, even for an existing key
      e.status = ST_FULL;
    end else begin
      for (int unsigned i = 0; i < ProbeLimit && !done && !have_empty; i++) begin
        s = probe_slot(r.key, i);
        if (shadow_tag[s] == TAG_EMPTY) begin
          have_empty = 1;
          empty = s;
        end else if (shadow_tag[s] == TAG_TOMB) begin
          if (!have_tomb) begin
            have_tomb = 1;
            tomb = s;
          end
        end else if (shadow_key[s] == r.key) begin
          e.value_out = shadow_val[s];
          shadow_val[s] = r.value;
          done = 1;
        end
      end
      if (!done) begin
        if (have_tomb) begin
          // first tombstone on the path is reused, used count unchanged
          shadow_tag[tomb] = TAG_LIVE;
          shadow_key[tomb] = r.key;
          shadow_val[tomb] = r.value;
          shadow_live++;
        end else if (have_empty) begin
          shadow_tag[empty] = TAG_LIVE;
          shadow_key[empty] = r.key;
          shadow_val[empty] = r.value;
          shadow_live++;
          shadow_used++;
        end else begin
          e.status = ST_FULL;
        end
      end
    end
    e.entry_count = shadow_live[CountBits-1:0];
    return e;
  endfunction

  task automatic add_req(kind_t k, logic [KeyBits-1:0] key, logic [ValueBits-1:0] v);
    req_t r;
    r.kind  = k;
    r.key   = key;
    r.value = v;
    pending_reqs.push_back(r);
  endtask

  // random key: mostly from a clustered pool so gets and removes hit
  function automatic logic [KeyBits-1:0] pick_key();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return key_pool[$urandom_range(0, PoolSize - 1)];
    if (pick < 80) return '0;
    return $urandom();
  endfunction

  // ---------------------------------------------------------------- driver
  int  send_gap;
  bit  quiet_send;     // stretch with no sender idling
  bit  pause_done;

  always @(posedge clk) begin
    req_t next_data;
    bit   next_valid;
    bit   took;
    next_data  = req_ch.data;
    next_valid = req_ch.valid;
    took       = 0;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap   = 0;
      quiet_send = 0;
      pause_done = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(table_apply(req_ch.data));
        sent_count++;
        took = 1;
        if (sent_count % 128 == 0) quiet_send = $urandom_range(0, 2) == 0;
        send_gap = quiet_send ? 0 : $urandom_range(0, 4);
      end
      if (!req_ch.valid || took) begin
        if (sent_count == PauseAtItem && !pause_done && expected_rsps.size() != 0) begin
          // sender pause until every response has come back
          next_valid = 0;
        end else if (send_gap > 0) begin
          send_gap--;
          next_valid = 0;
        end else if (pending_reqs.size() > 0) begin
          if (sent_count == PauseAtItem) pause_done = 1;
          next_valid = 1;
          next_data  = pending_reqs.pop_front();
        end else begin
          next_valid = 0;
        end
        req_ch.valid <= next_valid;
        req_ch.data  <= next_data;
      end
    end
  end

  // --------------------------------------------------------------- monitor
  int  recv_stall;
  int  hold_left;
  bit  hold_done;
  bit  quiet_recv;

  always @(posedge clk) begin
    rsp_t e;
    rsp_t got;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_stall = 0;
      hold_left  = 0;
      hold_done  = 0;
      quiet_recv = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        beat_count++;
        status_seen[got.status]++;
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected response beat: status %0d value %h count %0d",
                     got.status, got.value_out, got.entry_count);
        end else begin
          e = expected_rsps.pop_front();
          if (got.status !== e.status || got.value_out !== e.value_out ||
              got.entry_count !== e.entry_count) begin
            errors++;
            if (errors <= 10)
              $display("beat %0d mismatch: exp st %0d val %h cnt %0d, got st %0d val %h cnt %0d",
                       beat_count, e.status, e.value_out, e.entry_count,
                       got.status, got.value_out, got.entry_count);
          end
        end
        if (beat_count % 100 == 0) quiet_recv = $urandom_range(0, 2) == 0;
        recv_stall = quiet_recv ? 0 : $urandom_range(0, 4);
        if (beat_count == HoldAtBeat && !hold_done) begin
          hold_left = HoldCycles;
          hold_done = 1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // -------------------------------------------------------------- stimulus
  initial begin
    logic [KeyBits-1:0] k1;
    logic [KeyBits-1:0] k2;
    int unsigned        pick;
    kind_t              kd;
    logic [ValueBits-1:0] v;
    errors     = 0;
    sent_count = 0;
    beat_count = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    for (int i = 0; i < TableSize; i++) shadow_tag[i] = TAG_EMPTY;
    shadow_live = 0;
    shadow_used = 0;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    rsp_ch.ready = 1'b0;

    // clustered keys: few homes, random upper bits
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = KeyBits'({$urandom(), 6'd0}) | KeyBits'($urandom_range(0, 5) * 9);
      if (key_pool[i] == 0) key_pool[i] = TableSize;
    end

    // get on a freshly reset table, then a clear of an empty table
    add_req(KIND_GET, 32'h0000_0009, '0);
    add_req(KIND_CLEAR, $urandom(), $urandom());
    // get on an empty table
    add_req(KIND_GET, 32'h0000_0005, '0);
    // null key on get, put and remove, null value on put
    add_req(KIND_GET, '0, 32'h1234);
    add_req(KIND_PUT, '0, 32'h1234);
    add_req(KIND_REMOVE, '0, '0);
    add_req(KIND_PUT, 32'h0000_0007, '0);
    // extremes of key and value
    add_req(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
    add_req(KIND_PUT, 32'h0000_0001, 32'h0000_0001);
    add_req(KIND_GET, 32'hffff_ffff, '0);
    // replace returns the old value
    add_req(KIND_PUT, 32'hffff_ffff, 32'h5555_aaaa);
    add_req(KIND_GET, 32'hffff_ffff, '0);
    // collisions on one home, then a tombstone in the middle of the path
    add_req(KIND_PUT, 32'h0000_0041, 32'hbeef_0001);
    add_req(KIND_PUT, 32'h0000_0081, 32'hbeef_0002);
    add_req(KIND_REMOVE, 32'h0000_0041, '0);
    add_req(KIND_GET, 32'h0000_0081, '0);       // found past the tombstone
    add_req(KIND_PUT, 32'h0000_0081, 32'hbeef_0003); // key found past tombstone
    add_req(KIND_PUT, 32'h0000_00c1, 32'hbeef_0004); // reuses the tombstone
    add_req(KIND_REMOVE, 32'h0000_0041, '0);    // remove miss
    add_req(KIND_REMOVE, 32'h0000_0001, '0);
    add_req(KIND_GET, 32'h0000_0001, '0);
    add_req(KIND_CLEAR, '0, '0);
    add_req(KIND_GET, 32'h0000_00c1, '0);

    for (int n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) kd = KIND_PUT;
      else if (pick < 72) kd = KIND_GET;
      else if (pick < 97) kd = KIND_REMOVE;
      else kd = KIND_CLEAR;
      k1 = pick_key();
      v  = ($urandom_range(0, 29) == 0) ? '0 : $urandom();
      add_req(kd, k1, v);
    end

    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
    // settle time after the last response beat
    repeat (200) @(posedge clk);

    $display("covered %0d requests: ok %0d, not found %0d, full %0d, null %0d",
             sent_count, status_seen[ST_OK], status_seen[ST_NOTFOUND],
             status_seen[ST_FULL], status_seen[ST_NULL]);
    $display("%0d response beats checked, %0d mismatches", beat_count, errors);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(12 * 1500000);
    $display("timeout with %0d responses outstanding", expected_rsps.size());
    $display("testbench failed");
    $finish;
  end

endmodule

[filelist.f]
src/qpht_pkg.sv
src/qpht_if.sv
src/qpht_ram.sv
src/qpht_datapath.sv
src/qpht_ctrl.sv
src/quadratic_probe_hash_table.sv
tb/sv/testbench.sv
